// ===== design/mva_pkg.sv =====
// Shared types and constants for the MIDI voice allocator.
package mva_pkg;

  localparam int VOICES_DEF = 6;

  localparam logic [6:0] SPLIT_KEY   = 7'd60;
  localparam logic [7:0] LEAST_INIT  = 8'd255;
  localparam int         IDLE_W      = 16;
  localparam int         CHAN_W      = 3;

  localparam logic [2:0] MODE_SIX     = 3'd0;
  localparam logic [2:0] MODE_SPLIT33 = 3'd1;
  localparam logic [2:0] MODE_SPLIT31 = 3'd2;
  localparam logic [2:0] MODE_FOUR    = 3'd3;
  localparam logic [2:0] MODE_SPLIT41 = 3'd4;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic load_out;
  } mva_cmd_t;

  typedef struct packed {
    logic has_result;
  } mva_status_t;

endpackage

// ===== design/mva_in_if.sv =====
// Request channel: one MIDI event per transfer.
interface mva_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [6:0] key_number;
  logic [6:0] note_velocity;

  modport source (output valid, output operation, output key_number,
                  output note_velocity, input ready);
  modport sink   (input valid, input operation, input key_number,
                  input note_velocity, output ready);
endinterface

// ===== design/mva_out_if.sv =====
// Response channel: chosen voice and match flag per transfer.
interface mva_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] voice_channel;
  logic       key_matched;

  modport source (output valid, output voice_channel, output key_matched, input ready);
  modport sink   (input valid, input voice_channel, input key_matched, output ready);
endinterface

// ===== design/mva_ctrl.sv =====
// Controller: event sequencing and response valid handling.
module mva_ctrl
  import mva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mva_status_t status,
  output mva_cmd_t    cmd
);

  ctl_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status.has_result) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          cmd.apply    = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.load_out)
      out_valid_next = 1'b1;
    else if (out_ready)
      out_valid_next = 1'b0;
    else
      out_valid_next = out_valid;
  end

`ifndef NO_ASSERTIONS
  a_load_needs_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.has_result)
    else $error("response loaded for an event without result");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("response valid not raised after load");

  a_exec_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !cmd.apply) |-> (out_valid && !out_ready))
    else $error("event held without a blocked response");
`endif

endmodule

// ===== design/mva_datapath.sv =====
// Datapath: voice state, voice selection and response register.
module mva_datapath
  import mva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic [1:0]  operation,
  input  logic [6:0]  key_number,
  input  logic [6:0]  note_velocity,
  input  mva_cmd_t    cmd,
  output mva_status_t status,
  output logic [CHAN_W-1:0] voice_channel,
  output logic        key_matched
);

  localparam int VW = $clog2(VOICES);
  localparam int RW = $clog2(VOICES + 1);

  logic [2:0]        mode_q;
  op_t               op_q;
  logic [6:0]        key_q;
  logic [6:0]        vel_q;
  logic [6:0]        held_key [VOICES];
  logic [6:0]        held_vel [VOICES];
  logic [IDLE_W-1:0] idle_cnt [VOICES];
  logic [VOICES-1:0] busy;

  logic              low;
  logic [RW-1:0]     lo, hi;
  logic [VOICES-1:0] in_range, free;
  logic [VW-1:0]     free_pick, steal_pick, on_pick, off_pick;
  logic [IDLE_W-1:0] best;
  logic [7:0]        least;
  logic              off_hit;

  always_comb begin
    low = key_q < SPLIT_KEY;
    case (mode_q)
      MODE_SPLIT33: begin
        lo = low ? RW'(0) : RW'(3);
        hi = low ? RW'(3) : RW'(6);
      end
      MODE_SPLIT31: begin
        lo = low ? RW'(0) : RW'(3);
        hi = low ? RW'(3) : RW'(4);
      end
      MODE_FOUR: begin
        lo = RW'(0);
        hi = RW'(4);
      end
      MODE_SPLIT41: begin
        lo = low ? RW'(0) : RW'(4);
        hi = low ? RW'(4) : RW'(5);
      end
      default: begin
        lo = RW'(0);
        hi = RW'(VOICES);
      end
    endcase

    for (int v = 0; v < VOICES; v++)
      in_range[v] = (RW'(v) >= lo) && (RW'(v) < hi);
    free = in_range & ~busy;

    // last free voice, then first with greatest nonzero idle count
    free_pick = '0;
    for (int v = 0; v < VOICES; v++)
      if (free[v]) free_pick = VW'(v);
    best = '0;
    for (int v = 0; v < VOICES; v++)
      if (free[v] && idle_cnt[v] > best) begin
        best      = idle_cnt[v];
        free_pick = VW'(v);
      end

    // steal: first lowest velocity in range
    least      = LEAST_INIT;
    steal_pick = '0;
    for (int v = 0; v < VOICES; v++)
      if (in_range[v] && {1'b0, held_vel[v]} < least) begin
        least      = {1'b0, held_vel[v]};
        steal_pick = VW'(v);
      end

    on_pick = (|free) ? free_pick : steal_pick;

    off_hit  = 1'b0;
    off_pick = '0;
    for (int v = VOICES - 1; v >= 0; v--)
      if (held_key[v] == key_q) begin
        off_hit  = 1'b1;
        off_pick = VW'(v);
      end

    status.has_result = (op_q == OP_NOTE_ON) || (op_q == OP_NOTE_OFF);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(operation);
      key_q <= key_number;
      vel_q <= note_velocity;
    end
    if (cmd.load_out) begin
      if (op_q == OP_NOTE_ON) begin
        voice_channel <= CHAN_W'({1'b0, on_pick} + (VW + 1)'(1));
        key_matched   <= 1'b1;
      end else begin
        voice_channel <= off_hit ? CHAN_W'({1'b0, off_pick} + (VW + 1)'(1))
                                 : CHAN_W'(1);
        key_matched   <= off_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_SIX;
    end else if (cfg_we) begin
      mode_q <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int v = 0; v < VOICES; v++) begin
        held_key[v] <= '0;
        held_vel[v] <= '0;
        idle_cnt[v] <= '0;
      end
    end else if (cmd.apply) begin
      case (op_q)
        OP_NOTE_ON: begin
          busy[on_pick]     <= 1'b1;
          held_key[on_pick] <= key_q;
          held_vel[on_pick] <= vel_q;
          idle_cnt[on_pick] <= '0;
        end
        OP_NOTE_OFF: begin
          if (off_hit) begin
            busy[off_pick]     <= 1'b0;
            held_key[off_pick] <= '0;
            held_vel[off_pick] <= '0;
            idle_cnt[off_pick] <= '0;
          end
        end
        OP_TICK: begin
          for (int v = 0; v < VOICES; v++)
            if (!busy[v]) idle_cnt[v] <= idle_cnt[v] + IDLE_W'(1);
        end
        OP_CLEAR: begin
          busy <= '0;
          for (int v = 0; v < VOICES; v++) begin
            held_key[v] <= '0;
            held_vel[v] <= '0;
            idle_cnt[v] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_note_on_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && op_q == OP_NOTE_ON) |=> busy[$past(on_pick)])
    else $error("allocated voice not marked busy");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && op_q == OP_CLEAR) |=> (busy == '0))
    else $error("voices still busy after clear");
`endif

endmodule

// ===== design/midi_voice_allocator_unit.sv =====
// Top level of the MIDI voice allocator.
// Usage:
//   req carries one event per transfer: operation (note on, note off, tick,
//   clear all), key_number and note_velocity.
//   rsp carries one transfer for each note on and note off: voice_channel
//   (1..6) and key_matched. Tick and clear give no response.
//   cfg_we / cfg_wdata write voice_mode; write it only while no event is
//   in flight.
// Timing:
//   An event is captured in the idle state and executed in the exec state;
//   its response is registered as it executes. A new event is taken only
//   after the last one has executed; the two-state controller enforces this.
//   While a response waits on rsp, the next event is still taken; a note
//   event is held in execution until the pending response transfers.
// Reset (rst, synchronous): all voices free with zero key, velocity and
//   idle count, voice_mode six-voice, no response pending.
module midi_voice_allocator_unit
  import mva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  mva_in_if.sink     req,
  mva_out_if.source  rsp
);

  mva_cmd_t    cmd;
  mva_status_t status;

  mva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mva_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .operation     (req.operation),
    .key_number    (req.key_number),
    .note_velocity (req.note_velocity),
    .cmd           (cmd),
    .status        (status),
    .voice_channel (rsp.voice_channel),
    .key_matched   (rsp.key_matched)
  );

endmodule

// ===== bench/midi_voice_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for midi_voice_allocator_unit: random MIDI events checked against a voice predictor.
module midi_voice_allocator_unit_tb;
  import mva_pkg::*;

  localparam int NV = 6;
  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE = 6;
  localparam int PHASE_EVENTS = 130;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [2:0] MODE_ALIAS5 = 3'd5;
  localparam logic [2:0] MODE_ALIAS6 = 3'd6;
  localparam logic [2:0] MODE_ALIAS7 = 3'd7;

  typedef struct {
    op_t op;
    logic [6:0] key;
    logic [6:0] vel;
  } midi_ev_t;

  typedef struct {
    logic [2:0] chan;
    logic hit;
  } voice_reply_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_wdata;

  mva_in_if req_ch();
  mva_out_if rsp_ch();

  midi_voice_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  midi_ev_t pending_ev[$];
  voice_reply_t reply_q[$];

  logic [6:0] v_key[NV];
  bit v_busy[NV];
  logic [6:0] v_vel[NV];
  logic [15:0] v_idle[NV];
  logic [2:0] mode_q;

  bit in_taken;
  bit steady;
  int hold_token;
  int hold_seen;
  int hold_left;
  int errors;
  int checked;
  int n_ev[4];
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_voices();
    for (int v = 0; v < NV; v++) begin
      v_key[v] = '0;
      v_busy[v] = 1'b0;
      v_vel[v] = '0;
      v_idle[v] = '0;
    end
  endfunction

  function automatic int choose_voice(int lo, int hi);
    int free_n;
    int pick;
    logic [15:0] best;
    int least;
    free_n = 0;
    pick = lo;
    for (int v = lo; v < hi; v++) begin
      if (!v_busy[v]) begin
        free_n++;
        pick = v;
      end
    end
    if (free_n > 1) begin
      best = '0;
      for (int v = lo; v < hi; v++) begin
        if (!v_busy[v] && v_idle[v] > best) begin
          best = v_idle[v];
          pick = v;
        end
      end
    end else if (free_n == 0) begin
      least = int'(LEAST_INIT);
      for (int v = lo; v < hi; v++) begin
        if (int'(v_vel[v]) < least) begin
          least = int'(v_vel[v]);
          pick = v;
        end
      end
    end
    return pick;
  endfunction

  function automatic void track_event(midi_ev_t ev);
    int lo;
    int hi;
    int v;
    bit low;
    voice_reply_t r;
    n_ev[ev.op]++;
    case (ev.op)
      OP_NOTE_ON: begin
        low = ev.key < SPLIT_KEY;
        lo = 0;
        hi = NV;
        case (mode_q)
          MODE_SPLIT33: begin
            lo = low ? 0 : 3;
            hi = low ? 3 : 6;
          end
          MODE_SPLIT31: begin
            lo = low ? 0 : 3;
            hi = low ? 3 : 4;
          end
          MODE_FOUR: begin
            lo = 0;
            hi = 4;
          end
          MODE_SPLIT41: begin
            lo = low ? 0 : 4;
            hi = low ? 4 : 5;
          end
          default: ;
        endcase
        v = choose_voice(lo, hi);
        v_busy[v] = 1'b1;
        v_key[v] = ev.key;
        v_vel[v] = ev.vel;
        v_idle[v] = '0;
        r.chan = 3'(v + 1);
        r.hit = 1'b1;
        reply_q.push_back(r);
      end
      OP_NOTE_OFF: begin
        r.chan = 3'd1;
        r.hit = 1'b0;
        for (int i = 0; i < NV; i++) begin
          if (!r.hit && v_key[i] == ev.key) begin
            v_busy[i] = 1'b0;
            v_key[i] = '0;
            v_vel[i] = '0;
            v_idle[i] = '0;
            r.chan = 3'(i + 1);
            r.hit = 1'b1;
          end
        end
        reply_q.push_back(r);
      end
      OP_TICK: begin
        for (int i = 0; i < NV; i++)
          if (!v_busy[i]) v_idle[i] = v_idle[i] + 16'd1;
      end
      default: clear_voices();
    endcase
  endfunction

  always @(posedge clk) begin : watch
    voice_reply_t want;
    midi_ev_t ev;
    if (rst) begin
      in_taken <= 1'b0;
      mode_q = MODE_SIX;
      clear_voices();
    end else begin
      if (cfg_we) mode_q = cfg_wdata;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response: expected none, actual ch=%0d matched=%0b",
                   $time, rsp_ch.voice_channel, rsp_ch.key_matched);
        end else begin
          want = reply_q.pop_front();
          checked++;
          if (rsp_ch.voice_channel !== want.chan || rsp_ch.key_matched !== want.hit) begin
            errors++;
            $display("%0t: mismatch: expected ch=%0d matched=%0b, actual ch=%0d matched=%0b",
                     $time, want.chan, want.hit, rsp_ch.voice_channel, rsp_ch.key_matched);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        ev.op = op_t'(req_ch.operation);
        ev.key = req_ch.key_number;
        ev.vel = req_ch.note_velocity;
        track_event(ev);
      end
      in_taken <= req_ch.valid && req_ch.ready;
    end
  end

  always @(negedge clk) begin : drive_req
    midi_ev_t nx;
    bit give;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !in_taken) begin
      // hold until transfer
    end else begin
      give = pending_ev.size() > 0 && (steady || $urandom_range(0, 99) >= 21);
      if (give) begin
        nx = pending_ev.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.operation <= nx.op;
        req_ch.key_number <= nx.key;
        req_ch.note_velocity <= nx.vel;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || $urandom_range(0, 99) >= 21;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, reply_q.size());
      $display("midi_voice_allocator_unit verification failed");
      $finish;
    end
  end

  task automatic push_ev(op_t op, logic [6:0] key, logic [6:0] vel);
    midi_ev_t ev;
    ev.op = op;
    ev.key = key;
    ev.vel = vel;
    pending_ev.push_back(ev);
  endtask

  task automatic write_mode(logic [2:0] m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_ev.size() != 0 || req_ch.valid || reply_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 7'd0;
    if (r < 12) return 7'd127;
    if (r < 20) return SPLIT_KEY - 7'd1;
    if (r < 28) return SPLIT_KEY;
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [6:0] pick_vel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 16) return 7'd127;
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic gen_phase(int n);
    logic [6:0] keys_on[$];
    logic [6:0] key;
    int made;
    int r;
    int k;
    int idx;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_ev(op_t'($urandom_range(0, 3)), 7'($urandom), 7'($urandom));
        made++;
      end else if (r < 11) begin
        push_ev(OP_CLEAR, 7'($urandom), 7'($urandom));
        keys_on.delete();
        made++;
      end else if (r < 55) begin
        k = $urandom_range(1, 5);
        repeat (k) begin
          key = pick_key();
          push_ev(OP_NOTE_ON, key, pick_vel());
          keys_on.push_back(key);
          made++;
          if ($urandom_range(0, 3) == 0) begin
            push_ev(OP_TICK, 7'($urandom), 7'($urandom));
            made++;
          end
        end
      end else if (r < 85) begin
        if (keys_on.size() > 0) begin
          idx = $urandom_range(0, keys_on.size() - 1);
          key = keys_on[idx];
          keys_on.delete(idx);
        end else begin
          key = pick_key();
        end
        push_ev(OP_NOTE_OFF, key, 7'($urandom));
        made++;
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) push_ev(OP_TICK, 7'($urandom), 7'($urandom));
        made += k;
      end
      if (keys_on.size() > 12) keys_on.delete(0);
    end
  endtask

  logic [2:0] phase_mode[10] = '{MODE_SPLIT33, MODE_SPLIT31, MODE_FOUR, MODE_SPLIT41,
                                 MODE_ALIAS5, MODE_SIX, MODE_ALIAS7, MODE_ALIAS6,
                                 MODE_SPLIT41, MODE_SPLIT33};

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = MODE_SIX;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_TICK;
    req_ch.key_number = '0;
    req_ch.note_velocity = '0;
    rsp_ch.ready = 1'b0;
    steady = 1'b0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    errors = 0;
    checked = 0;
    cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_mode(MODE_SIX);
    // free voices after reset hold key 0, then a miss
    push_ev(OP_NOTE_OFF, 7'd0, 7'd0);
    push_ev(OP_NOTE_OFF, 7'd5, 7'd127);
    push_ev(OP_NOTE_ON, 7'd127, 7'd127);
    push_ev(OP_TICK, 7'd0, 7'd0);
    push_ev(OP_NOTE_ON, 7'd0, 7'd0);
    push_ev(OP_NOTE_ON, SPLIT_KEY - 7'd1, 7'd64);
    push_ev(OP_NOTE_ON, SPLIT_KEY, 7'd1);
    push_ev(OP_NOTE_ON, 7'd61, 7'd100);
    push_ev(OP_NOTE_ON, 7'd62, 7'd3);
    // all busy: steal lowest velocity
    push_ev(OP_NOTE_ON, 7'd70, 7'd50);
    push_ev(OP_NOTE_ON, 7'd71, 7'd50);
    push_ev(OP_NOTE_OFF, 7'd127, 7'd0);
    push_ev(OP_NOTE_OFF, SPLIT_KEY, 7'd0);
    push_ev(OP_TICK, 7'd127, 7'd127);
    push_ev(OP_TICK, 7'd0, 7'd0);
    push_ev(OP_NOTE_OFF, 7'd0, 7'd0);
    push_ev(OP_NOTE_ON, 7'd80, 7'd0);
    push_ev(OP_NOTE_ON, 7'd81, 7'd127);
    push_ev(OP_CLEAR, 7'd127, 7'd127);
    push_ev(OP_TICK, 7'd0, 7'd0);
    push_ev(OP_NOTE_OFF, 7'd0, 7'd0);
    push_ev(OP_NOTE_ON, 7'd0, 7'd127);
    push_ev(OP_NOTE_OFF, 7'd0, 7'd0);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_mode(phase_mode[p]);
      steady = (p == 5);
      if (p == 2 || p == 8) hold_token++;
      gen_phase(PHASE_EVENTS);
      // sender waits for every response before the next setting
      drain();
    end
    steady = 1'b0;

    $display("events: %0d note on, %0d note off, %0d tick, %0d clear over 11 mode settings",
             n_ev[OP_NOTE_ON], n_ev[OP_NOTE_OFF], n_ev[OP_TICK], n_ev[OP_CLEAR]);
    $display("responses checked: %0d, mismatches: %0d, cycles: %0d", checked, errors, cycles);
    if (errors == 0) begin
      $display("midi_voice_allocator_unit verification clean");
    end else begin
      $display("midi_voice_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
